FILE: src/qpi_pkg.sv
// qpi_pkg: shared types, constants, tables and the microprogram of the
// quaternion pose integrator. No dependencies.
package qpi_pkg;

	localparam int CORDIC_ITERATIONS = 24;
	localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;

	localparam int DW = 64;          // register file word
	localparam int CW = 34;          // cordic datapath width
	localparam int MUL_B_W = 36;     // serial multiplier operand width
	localparam int DEN_W = 32;       // divider divisor width
	localparam int RF_AW = 6;
	localparam int RF_DEPTH = 1 << RF_AW;
	localparam int PC_W = 7;

	localparam logic [30:0] PI_Q29 = 31'h6487ED51;
	localparam logic [CW-1:0] CORDIC_GAIN_Q30 = 34'h026DD3B6A;
	localparam logic [DW-1:0] ONE_Q30 = 64'h0000_0000_4000_0000;
	localparam logic [15:0] ANG_DIV = 16'd46080;
	localparam logic [15:0] ANG_HALF = 16'd23040;

	// sign of each Hamilton product term, indexed component*4 + term
	localparam logic [15:0] QSIGN = 16'h428E;

	localparam logic [2:0] SEL_ROLL = 3'd0;
	localparam logic [2:0] SEL_HEADING = 3'd1;
	localparam logic [2:0] SEL_ATTITUDE = 3'd2;
	localparam logic [2:0] SEL_SIDE = 3'd0;
	localparam logic [2:0] SEL_UP = 3'd1;
	localparam logic [2:0] SEL_FWD = 3'd2;

	typedef enum logic [RF_AW-1:0] {
		R_C1, R_S1, R_C2, R_S2, R_C3, R_S3,
		R_C1C2, R_S1S2, R_S1C2, R_C1S2,
		R_RW, R_RX, R_RY, R_RZ,
		R_OW, R_OX, R_OY, R_OZ,
		R_QW, R_QX, R_QY, R_QZ,
		R_NW, R_NX, R_NY, R_NZ,
		R_MW, R_MX, R_MY, R_MZ,
		R_TW, R_TX, R_TY, R_TZ,
		R_KW, R_KX, R_KY, R_KZ,
		R_PX, R_PY, R_PZ,
		R_N2, R_NORM, R_RECIP
	} reg_t;

	typedef enum logic [3:0] {
		OP_ANG, OP_MUL, OP_LDACC, OP_MOV, OP_SQRT, OP_RECIP, OP_LDMV, OP_OUT, OP_END
	} op_t;

	typedef struct packed {
		op_t op;
		reg_t ra;
		reg_t rb;
		reg_t rd;
		logic [2:0] sel;
		logic neg;
		logic first;
		logic last;
		logic sat;
		logic raw;
		logic nrm;
	} instr_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ISSUE, ST_EXEC, ST_HSTART, ST_HDIV, ST_CORW, ST_WBS, ST_MULW, ST_DSW
	} st_t;

	typedef struct packed {
		logic start;
		logic sqrt;
	} ds_req_t;

	function automatic logic [CW-1:0] atan_q30(logic [4:0] i);
		logic [CW-1:0] r;
		unique case (i)
			5'd0: r = 34'h03243F6A8;
			5'd1: r = 34'h01DAC6705;
			5'd2: r = 34'h00FADBAFC;
			5'd3: r = 34'h007F56EA6;
			5'd4: r = 34'h003FEAB76;
			5'd5: r = 34'h001FFD55B;
			5'd6: r = 34'h000FFFAAA;
			5'd7: r = 34'h0007FFF55;
			5'd8: r = 34'h0003FFFEA;
			5'd9: r = 34'h0001FFFFD;
			5'd10: r = 34'h0000FFFFF;
			5'd11: r = 34'h00007FFFF;
			5'd12: r = 34'h00003FFFF;
			5'd13: r = 34'h00001FFFF;
			5'd14: r = 34'h00000FFFF;
			5'd15: r = 34'h000007FFF;
			5'd16: r = 34'h000003FFF;
			5'd17: r = 34'h000001FFF;
			5'd18: r = 34'h000000FFF;
			5'd19: r = 34'h0000007FF;
			5'd20: r = 34'h0000003FF;
			5'd21: r = 34'h0000001FF;
			5'd22: r = 34'h0000000FF;
			5'd23: r = 34'h00000007F;
			5'd24: r = 34'h00000003F;
			5'd25: r = 34'h00000001F;
			5'd26: r = 34'h00000000F;
			5'd27: r = 34'h000000007;
			5'd28: r = 34'h000000003;
			5'd29: r = 34'h000000001;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [DW-1:0] sat32(logic [DW-1:0] v);
		logic [DW-1:0] r;
		if (!v[DW-1] && (v[DW-2:31] != '0))
			r = 64'h0000_0000_7FFF_FFFF;
		else if (v[DW-1] && (v[DW-2:31] != '1))
			r = 64'hFFFF_FFFF_8000_0000;
		else
			r = v;
		return r;
	endfunction

	function automatic reg_t radd(reg_t b, int k);
		return reg_t'(RF_AW'(int'(b) + k));
	endfunction

	function automatic instr_t mk(op_t op, reg_t ra, reg_t rb, reg_t rd, logic [2:0] sel,
			logic neg, logic first, logic last, logic sat, logic raw, logic nrm);
		instr_t r;
		r.op = op;
		r.ra = ra;
		r.rb = rb;
		r.rd = rd;
		r.sel = sel;
		r.neg = neg;
		r.first = first;
		r.last = last;
		r.sat = sat;
		r.raw = raw;
		r.nrm = nrm;
		return r;
	endfunction

	// term t of component c of the product a*b
	function automatic instr_t qterm(int c, int t, reg_t a, reg_t b, reg_t d,
			logic first_ok, logic sat);
		return mk(OP_MUL, radd(a, t), radd(b, c ^ t), d, 3'd0, QSIGN[c * 4 + t],
			first_ok && (t == 0), t == 3, sat, 1'b0, 1'b0);
	endfunction

	function automatic instr_t prog(logic [PC_W-1:0] pc);
		instr_t r;
		int p;
		int j;
		int k;
		int g;
		p = int'(pc);
		r = mk(OP_END, R_MW, R_MW, R_MW, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		if (p == 0)
			r = mk(OP_ANG, R_MW, R_S1, R_C1, SEL_HEADING, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		else if (p == 1)
			r = mk(OP_ANG, R_MW, R_S2, R_C2, SEL_ATTITUDE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		else if (p == 2)
			r = mk(OP_ANG, R_MW, R_S3, R_C3, SEL_ROLL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		else if (p == 3)
			r = mk(OP_MUL, R_C1, R_C2, R_C1C2, 3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		else if (p == 4)
			r = mk(OP_MUL, R_S1, R_S2, R_S1S2, 3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		else if (p == 5)
			r = mk(OP_MUL, R_S1, R_C2, R_S1C2, 3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		else if (p == 6)
			r = mk(OP_MUL, R_C1, R_S2, R_C1S2, 3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		else if (p == 7)
			r = mk(OP_MUL, R_C1C2, R_C3, R_RW, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		else if (p == 8)
			r = mk(OP_MUL, R_S1S2, R_S3, R_RW, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
		else if (p == 9)
			r = mk(OP_MUL, R_C1C2, R_S3, R_RX, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		else if (p == 10)
			r = mk(OP_MUL, R_S1S2, R_C3, R_RX, 3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
		else if (p == 11)
			r = mk(OP_MUL, R_S1C2, R_C3, R_RY, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		else if (p == 12)
			r = mk(OP_MUL, R_C1S2, R_S3, R_RY, 3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
		else if (p == 13)
			r = mk(OP_MUL, R_C1S2, R_C3, R_RZ, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		else if (p == 14)
			r = mk(OP_MUL, R_S1C2, R_S3, R_RZ, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
		else if (p < 31) begin
			j = p - 15;
			r = qterm(j / 4, j % 4, R_OW, R_RW, radd(R_QW, j / 4), 1'b1, 1'b1);
		end else if (p < 35) begin
			k = p - 31;
			r = mk(OP_MUL, radd(R_QW, k), radd(R_QW, k), R_N2, 3'd0, 1'b0,
				k == 0, k == 3, 1'b0, 1'b1, 1'b0);
		end else if (p == 35)
			r = mk(OP_SQRT, R_N2, R_MW, R_NORM, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		else if (p == 36)
			r = mk(OP_RECIP, R_NORM, R_MW, R_RECIP, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		else if (p < 41) begin
			k = p - 37;
			r = mk(OP_MUL, R_RECIP, radd(R_QW, k), radd(R_NW, k), 3'd0, 1'b0,
				1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
		end else if (p < 45) begin
			k = p - 41;
			r = mk(OP_MOV, radd(R_NW, k), R_MW, radd(R_OW, k), 3'd0, 1'b0,
				1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
		end else if (p < 48) begin
			k = p - 45;
			r = mk(OP_LDMV, R_MW, R_MW, radd(R_MX, k), 3'(k), k != 1,
				1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		end else if (p < 64) begin
			j = p - 48;
			r = qterm(j / 4, j % 4, R_NW, R_MW, radd(R_TW, j / 4), 1'b1, 1'b0);
		end else if (p < 68) begin
			k = p - 64;
			r = mk(OP_MOV, radd(R_NW, k), R_MW, radd(R_KW, k), 3'd0, k != 0,
				1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		end else if (p < 83) begin
			// position gets the rotated move added, one component per group of five
			j = p - 68;
			if (j < 5)
				g = 0;
			else if (j < 10)
				g = 1;
			else
				g = 2;
			k = j - 5 * g;
			if (k == 0)
				r = mk(OP_LDACC, radd(R_PX, g), R_MW, R_MW, 3'd0, 1'b0,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			else
				r = qterm(g + 1, k - 1, R_TW, R_KW, radd(R_PX, g), 1'b0, 1'b1);
		end else if (p < 90) begin
			k = p - 83;
			r = mk(OP_OUT, (k < 4) ? radd(R_OW, k) : radd(R_PX, k - 4), R_MW, R_MW, 3'(k),
				1'b0, 1'b0, k == 6, 1'b0, 1'b0, 1'b0);
		end
		return r;
	endfunction

endpackage

FILE: src/qpi_rf.sv
// qpi_rf: working register file, one write and two registered reads.
// Entries never written read as their reset value. Uses qpi_pkg.
module qpi_rf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  qpi_pkg::reg_t              waddr,
	input  logic [qpi_pkg::DW-1:0]     wdata,
	input  qpi_pkg::reg_t              raddr_a,
	input  qpi_pkg::reg_t              raddr_b,
	output logic [qpi_pkg::DW-1:0]     rdata_a,
	output logic [qpi_pkg::DW-1:0]     rdata_b
);

	logic [qpi_pkg::DW-1:0] mem [qpi_pkg::RF_DEPTH];
	logic [qpi_pkg::RF_DEPTH-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// identity orientation until first written, everything else zero
	always_ff @(posedge clk) begin
		if (valid_q[raddr_a])
			rdata_a <= mem[raddr_a];
		else
			rdata_a <= (raddr_a == qpi_pkg::R_OW) ? qpi_pkg::ONE_Q30 : '0;
		if (valid_q[raddr_b])
			rdata_b <= mem[raddr_b];
		else
			rdata_b <= (raddr_b == qpi_pkg::R_OW) ? qpi_pkg::ONE_Q30 : '0;
	end

endmodule

FILE: src/qpi_mul.sv
// qpi_mul: bit-serial signed multiplier, one bit of b per cycle, low 64 bits
// of the product, optionally rounded to Q30. Uses qpi_pkg.
module qpi_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           raw,
	input  logic [qpi_pkg::DW-1:0]         a,
	input  logic [qpi_pkg::MUL_B_W-1:0]    b,
	output logic [qpi_pkg::DW-1:0]         res,
	output logic                           done
);

	localparam int CNT_W = $clog2(qpi_pkg::MUL_B_W);

	logic [qpi_pkg::DW-1:0] acc_q;
	logic [qpi_pkg::DW-1:0] a_q;
	logic [qpi_pkg::MUL_B_W-1:0] b_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic raw_q;
	logic done_q;
	logic [qpi_pkg::DW-1:0] rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(qpi_pkg::MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// sign bit of b carries negative weight
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= a;
			b_q <= b;
			raw_q <= raw;
		end else if (busy_q) begin
			if (b_q[0]) begin
				if (cnt_q == CNT_W'(qpi_pkg::MUL_B_W - 1))
					acc_q <= acc_q - a_q;
				else
					acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[qpi_pkg::DW-2:0], 1'b0};
			b_q <= {1'b0, b_q[qpi_pkg::MUL_B_W-1:1]};
		end
	end

	assign rnd = acc_q + 64'h0000_0000_2000_0000;
	assign res = raw_q ? acc_q : {{30{rnd[63]}}, rnd[63:30]};
	assign done = done_q;

endmodule

FILE: src/qpi_divsqrt.sv
// qpi_divsqrt: restoring unsigned divider (one quotient bit a cycle) and
// integer square root (one root bit a cycle). Uses qpi_pkg.
module qpi_divsqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  qpi_pkg::ds_req_t               req,
	input  logic [qpi_pkg::DW-1:0]         num,
	input  logic [qpi_pkg::DEN_W-1:0]      den,
	output logic [qpi_pkg::DW-1:0]         res,
	output logic                           done
);

	logic [qpi_pkg::DW-1:0] num_q;
	logic [qpi_pkg::DW-1:0] quo_q;
	logic [qpi_pkg::DEN_W-1:0] den_q;
	logic [qpi_pkg::DEN_W:0] rem_q;
	logic [35:0] srem_q;
	logic [31:0] root_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic sqrt_q;
	logic done_q;

	logic [qpi_pkg::DEN_W:0] dsh;
	logic [35:0] ssh;
	logic [35:0] trial;
	logic last;

	assign dsh = {rem_q[qpi_pkg::DEN_W-1:0], num_q[qpi_pkg::DW-1]};
	assign ssh = {srem_q[33:0], num_q[qpi_pkg::DW-1:qpi_pkg::DW-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign last = sqrt_q ? (cnt_q == 7'd31) : (cnt_q == 7'(qpi_pkg::DW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= num;
			den_q <= den;
			sqrt_q <= req.sqrt;
			rem_q <= '0;
			srem_q <= '0;
			quo_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (sqrt_q) begin
				num_q <= {num_q[qpi_pkg::DW-3:0], 2'b00};
				if (ssh >= trial) begin
					srem_q <= ssh - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= ssh;
					root_q <= {root_q[30:0], 1'b0};
				end
			end else begin
				num_q <= {num_q[qpi_pkg::DW-2:0], 1'b0};
				if (dsh >= {1'b0, den_q}) begin
					rem_q <= dsh - {1'b0, den_q};
					quo_q <= {quo_q[qpi_pkg::DW-2:0], 1'b1};
				end else begin
					rem_q <= dsh;
					quo_q <= {quo_q[qpi_pkg::DW-2:0], 1'b0};
				end
			end
		end
	end

	assign res = sqrt_q ? {32'b0, root_q} : quo_q;
	assign done = done_q;

endmodule

FILE: src/qpi_cordic.sv
// qpi_cordic: iterative rotation-mode CORDIC, one micro-rotation a cycle,
// gives cosine and sine in Q4.30. Uses qpi_pkg.
module qpi_cordic (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [qpi_pkg::CW-1:0]         ang,
	output logic [qpi_pkg::CW-1:0]         cos_o,
	output logic [qpi_pkg::CW-1:0]         sin_o,
	output logic                           done
);

	logic signed [qpi_pkg::CW-1:0] x_q;
	logic signed [qpi_pkg::CW-1:0] y_q;
	logic signed [qpi_pkg::CW-1:0] z_q;
	logic [4:0] i_q;
	logic busy_q;
	logic done_q;
	logic signed [qpi_pkg::CW-1:0] xs;
	logic signed [qpi_pkg::CW-1:0] ys;
	logic [qpi_pkg::CW-1:0] at;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = qpi_pkg::atan_q30(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 5'(qpi_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= qpi_pkg::CORDIC_GAIN_Q30;
			y_q <= '0;
			z_q <= ang;
		end else if (busy_q) begin
			if (!z_q[qpi_pkg::CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign cos_o = x_q;
	assign sin_o = y_q;
	assign done = done_q;

endmodule

FILE: src/quaternion_pose_integrator.sv
// quaternion_pose_integrator: top level, microprogram sequencer driving the
// register file, serial multiplier, divider/root unit and cordic. Uses qpi_pkg.
//
//  channel | handshake            | words
//  in      | in_valid / in_ready  | roll_deg heading_deg attitude_deg move_side move_up move_fwd
//  out     | out_valid / out_ready| quat_w quat_x quat_y quat_z pos_x pos_y pos_z
//
// each word runs 64 products on the bit-serial multiplier, three angles through
// the 64-step divider and 24-step cordic, then a root and a reciprocal.
// reset restores identity orientation and zero position at once.
// a new word is taken while a result waits; its run stalls at the result write.
module quaternion_pose_integrator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] roll_deg,
	input  logic signed [15:0] heading_deg,
	input  logic signed [15:0] attitude_deg,
	input  logic signed [23:0] move_side,
	input  logic signed [23:0] move_up,
	input  logic signed [23:0] move_fwd,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z
);

	localparam int DW = qpi_pkg::DW;
	localparam int CW = qpi_pkg::CW;

	qpi_pkg::st_t st_q, st_d;
	logic [qpi_pkg::PC_W-1:0] pc_q;
	qpi_pkg::instr_t ins;

	logic signed [15:0] roll_q, heading_q, attitude_q;
	logic signed [23:0] side_q, up_q, fwd_q;
	logic [DW-1:0] acc_q;
	logic ident_q;
	logic [47:0] angp_q;
	logic ang_neg_q;
	logic out_valid_q;
	logic [31:0] out_q [7];

	logic we;
	qpi_pkg::reg_t waddr;
	logic [DW-1:0] wdata;
	logic [DW-1:0] rdata_a, rdata_b;

	logic mul_start;
	logic [DW-1:0] mul_res;
	logic mul_done;
	qpi_pkg::ds_req_t ds_req;
	logic [DW-1:0] ds_num;
	logic [qpi_pkg::DEN_W-1:0] ds_den;
	logic [DW-1:0] ds_res;
	logic ds_done;
	logic cor_start;
	logic [CW-1:0] cor_ang;
	logic [CW-1:0] cor_cos, cor_sin;
	logic cor_done;

	logic [DW-1:0] accn;
	logic [DW-1:0] movv;
	logic signed [16:0] degx;
	logic [16:0] mag;
	logic signed [23:0] mvsel;
	logic [DW-1:0] mvx;
	logic advance;
	logic out_load;

	assign ins = qpi_pkg::prog(pc_q);

	qpi_rf u_rf (
		.clk(clk), .arst_n(arst_n), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ins.ra), .raddr_b(ins.rb), .rdata_a(rdata_a), .rdata_b(rdata_b)
	);

	qpi_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .raw(ins.raw), .a(rdata_a),
		.b(rdata_b[qpi_pkg::MUL_B_W-1:0]), .res(mul_res), .done(mul_done)
	);

	qpi_divsqrt u_ds (
		.clk(clk), .arst_n(arst_n), .req(ds_req), .num(ds_num), .den(ds_den),
		.res(ds_res), .done(ds_done)
	);

	qpi_cordic u_cor (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .ang(cor_ang),
		.cos_o(cor_cos), .sin_o(cor_sin), .done(cor_done)
	);

	always_comb begin
		unique case (ins.sel)
			qpi_pkg::SEL_ROLL: degx = 17'(roll_q);
			qpi_pkg::SEL_HEADING: degx = 17'(heading_q);
			default: degx = 17'(attitude_q);
		endcase
		mag = degx[16] ? 17'(-degx) : 17'(degx);
		unique case (ins.sel)
			qpi_pkg::SEL_SIDE: mvsel = side_q;
			qpi_pkg::SEL_UP: mvsel = up_q;
			default: mvsel = fwd_q;
		endcase
		mvx = {{40{mvsel[23]}}, mvsel};
		movv = ins.neg ? -rdata_a : rdata_a;
		if (ins.sat)
			movv = qpi_pkg::sat32(movv);
		accn = (ins.first ? '0 : acc_q) + (ins.neg ? -mul_res : mul_res);
	end

	always_comb begin
		st_d = st_q;
		advance = 1'b0;
		we = 1'b0;
		waddr = ins.rd;
		wdata = '0;
		mul_start = 1'b0;
		ds_req = '{start: 1'b0, sqrt: 1'b0};
		ds_num = {16'b0, angp_q};
		ds_den = qpi_pkg::DEN_W'(qpi_pkg::ANG_DIV);
		cor_start = 1'b0;
		cor_ang = ang_neg_q ? CW'(-ds_res[CW-1:0]) : ds_res[CW-1:0];
		out_load = 1'b0;
		unique case (st_q)
			qpi_pkg::ST_IDLE: begin
				if (in_valid)
					st_d = qpi_pkg::ST_ISSUE;
			end
			qpi_pkg::ST_ISSUE: st_d = qpi_pkg::ST_EXEC;
			qpi_pkg::ST_EXEC: begin
				unique case (ins.op)
					qpi_pkg::OP_ANG: st_d = qpi_pkg::ST_HSTART;
					qpi_pkg::OP_MUL: begin
						mul_start = 1'b1;
						st_d = qpi_pkg::ST_MULW;
					end
					qpi_pkg::OP_LDACC: advance = 1'b1;
					qpi_pkg::OP_MOV: begin
						we = 1'b1;
						wdata = movv;
						advance = 1'b1;
					end
					qpi_pkg::OP_SQRT: begin
						ds_req = '{start: 1'b1, sqrt: 1'b1};
						ds_num = rdata_a;
						st_d = qpi_pkg::ST_DSW;
					end
					qpi_pkg::OP_RECIP: begin
						// zero norm leaves the reciprocal unused
						if (rdata_a == '0) begin
							advance = 1'b1;
						end else begin
							ds_req = '{start: 1'b1, sqrt: 1'b0};
							ds_num = (64'd1 << 60) + {33'b0, rdata_a[31:1]};
							ds_den = rdata_a[qpi_pkg::DEN_W-1:0];
							st_d = qpi_pkg::ST_DSW;
						end
					end
					qpi_pkg::OP_LDMV: begin
						we = 1'b1;
						wdata = ins.neg ? -mvx : mvx;
						advance = 1'b1;
					end
					qpi_pkg::OP_OUT: begin
						if (!out_valid_q) begin
							out_load = 1'b1;
							advance = 1'b1;
						end
					end
					default: st_d = qpi_pkg::ST_IDLE;
				endcase
			end
			qpi_pkg::ST_HSTART: begin
				ds_req = '{start: 1'b1, sqrt: 1'b0};
				st_d = qpi_pkg::ST_HDIV;
			end
			qpi_pkg::ST_HDIV: begin
				if (ds_done) begin
					cor_start = 1'b1;
					st_d = qpi_pkg::ST_CORW;
				end
			end
			qpi_pkg::ST_CORW: begin
				if (cor_done) begin
					we = 1'b1;
					wdata = {{(DW-CW){cor_cos[CW-1]}}, cor_cos};
					st_d = qpi_pkg::ST_WBS;
				end
			end
			qpi_pkg::ST_WBS: begin
				we = 1'b1;
				waddr = ins.rb;
				wdata = {{(DW-CW){cor_sin[CW-1]}}, cor_sin};
				advance = 1'b1;
			end
			qpi_pkg::ST_MULW: begin
				if (mul_done) begin
					we = ins.last;
					if (ins.nrm && ident_q)
						wdata = (ins.rd == qpi_pkg::R_NW) ? qpi_pkg::ONE_Q30 : '0;
					else if (ins.sat)
						wdata = qpi_pkg::sat32(accn);
					else
						wdata = accn;
					advance = 1'b1;
				end
			end
			qpi_pkg::ST_DSW: begin
				if (ds_done) begin
					we = 1'b1;
					wdata = ds_res;
					advance = 1'b1;
				end
			end
			default: st_d = qpi_pkg::ST_IDLE;
		endcase
		if (advance)
			st_d = qpi_pkg::ST_ISSUE;
	end

	assign in_ready = (st_q == qpi_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= qpi_pkg::ST_IDLE;
			pc_q <= '0;
			ident_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == qpi_pkg::ST_IDLE)
				pc_q <= '0;
			else if (advance)
				pc_q <= pc_q + 1'b1;
			if (st_q == qpi_pkg::ST_EXEC && ins.op == qpi_pkg::OP_RECIP)
				ident_q <= (rdata_a == '0);
			if (out_load && ins.last)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			roll_q <= roll_deg;
			heading_q <= heading_deg;
			attitude_q <= attitude_deg;
			side_q <= move_side;
			up_q <= move_up;
			fwd_q <= move_fwd;
		end
		if (st_q == qpi_pkg::ST_EXEC && ins.op == qpi_pkg::OP_ANG) begin
			angp_q <= 48'(mag) * 48'(qpi_pkg::PI_Q29) + 48'(qpi_pkg::ANG_HALF);
			ang_neg_q <= degx[16];
		end
		if (st_q == qpi_pkg::ST_EXEC && ins.op == qpi_pkg::OP_LDACC)
			acc_q <= rdata_a;
		else if (st_q == qpi_pkg::ST_MULW && mul_done)
			acc_q <= accn;
		if (out_load)
			out_q[ins.sel] <= rdata_a[31:0];
	end

	assign out_valid = out_valid_q;
	assign quat_w = out_q[0];
	assign quat_x = out_q[1];
	assign quat_y = out_q[2];
	assign quat_z = out_q[3];
	assign pos_x = out_q[4];
	assign pos_y = out_q[5];
	assign pos_z = out_q[6];

endmodule

FILE: tb/quaternion_pose_integrator_test.sv
// quaternion_pose_integrator_test: self-checking bench for the pose integrator.
// Carries its own fixed-point model of rotation, normalisation and position update.
// Depends on qpi_pkg and quaternion_pose_integrator.
module quaternion_pose_integrator_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] roll, heading, attitude;
		logic signed [23:0] side, up, fwd;
		bit drain;
	} tick_t;

	typedef struct {
		logic signed [31:0] qw, qx, qy, qz, px, py, pz;
	} pose_t;

	typedef struct {
		longint w, x, y, z;
	} quat_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [15:0] roll_deg, heading_deg, attitude_deg;
	logic signed [23:0] move_side, move_up, move_fwd;
	logic signed [31:0] quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z;

	tick_t ticks_pending[$];
	pose_t poses_expected[$];
	longint orient[4];
	longint posn[3];
	int mismatches = 0;
	int idle_cycles = 0;
	bit in_fire = 0, out_fire = 0;
	int in_gap = 0, out_stall = 0;
	int send_count = 0, recv_count = 0;

	quaternion_pose_integrator uut (.*);

	always begin
		clk = 0;
		#6;
		clk = 1;
		#6;
	end

	function automatic longint mul_q30(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint half_rad(longint deg);
		longint unsigned mag;
		longint r;
		mag = (deg < 0) ? -deg : deg;
		r = (mag * 64'd1686629713 + 64'd23040) / 64'd46080;
		return (deg < 0) ? -r : r;
	endfunction

	task automatic sin_cos(input longint ang, output longint c, output longint s);
		longint arctan[32];
		longint x, y, z, nx;
		arctan = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
			32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
			32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
			32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
			32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
			32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001, 0, 0};
		x = 64'h26DD3B6A;
		y = 0;
		z = ang;
		for (int i = 0; i < qpi_pkg::CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan[i];
			end
			x = nx;
		end
		c = x;
		s = y;
	endtask

	function automatic quat_t hamilton(quat_t a, quat_t b);
		quat_t o;
		o.w = mul_q30(a.w, b.w) - mul_q30(a.x, b.x) - mul_q30(a.y, b.y) - mul_q30(a.z, b.z);
		o.x = mul_q30(a.w, b.x) + mul_q30(a.x, b.w) + mul_q30(a.y, b.z) - mul_q30(a.z, b.y);
		o.y = mul_q30(a.w, b.y) - mul_q30(a.x, b.z) + mul_q30(a.y, b.w) + mul_q30(a.z, b.x);
		o.z = mul_q30(a.w, b.z) + mul_q30(a.x, b.y) - mul_q30(a.y, b.x) + mul_q30(a.z, b.w);
		return o;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned square_mag(longint v);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		return m * m;
	endfunction

	function automatic quat_t unit_quat(quat_t q);
		longint unsigned n2, norm, recip;
		q.w = clamp32(q.w);
		q.x = clamp32(q.x);
		q.y = clamp32(q.y);
		q.z = clamp32(q.z);
		n2 = square_mag(q.w) + square_mag(q.x) + square_mag(q.y) + square_mag(q.z);
		norm = root_floor(n2);
		// all-zero product falls back to identity
		if (norm == 0) begin
			q = '{64'h40000000, 0, 0, 0};
			return q;
		end
		recip = ((64'd1 << 60) + norm / 2) / norm;
		q.w = mul_q30(q.w, longint'(recip));
		q.x = mul_q30(q.x, longint'(recip));
		q.y = mul_q30(q.y, longint'(recip));
		q.z = mul_q30(q.z, longint'(recip));
		return q;
	endfunction

	task automatic predict_pose(input tick_t t);
		longint c1, s1, c2, s2, c3, s3, c1c2, s1s2;
		quat_t rot, cur, q, mv, tq, qc, v;
		pose_t p;
		sin_cos(half_rad(longint'(t.heading)), c1, s1);
		sin_cos(half_rad(longint'(t.attitude)), c2, s2);
		sin_cos(half_rad(longint'(t.roll)), c3, s3);
		c1c2 = mul_q30(c1, c2);
		s1s2 = mul_q30(s1, s2);
		rot.w = mul_q30(c1c2, c3) - mul_q30(s1s2, s3);
		rot.x = mul_q30(c1c2, s3) + mul_q30(s1s2, c3);
		rot.y = mul_q30(mul_q30(s1, c2), c3) + mul_q30(mul_q30(c1, s2), s3);
		rot.z = mul_q30(mul_q30(c1, s2), c3) - mul_q30(mul_q30(s1, c2), s3);
		cur = '{orient[0], orient[1], orient[2], orient[3]};
		q = unit_quat(hamilton(cur, rot));
		orient = '{clamp32(q.w), clamp32(q.x), clamp32(q.y), clamp32(q.z)};
		mv = '{0, -longint'(t.side), longint'(t.up), -longint'(t.fwd)};
		tq = hamilton(q, mv);
		qc = '{q.w, -q.x, -q.y, -q.z};
		v = hamilton(tq, qc);
		posn[0] = clamp32(posn[0] + v.x);
		posn[1] = clamp32(posn[1] + v.y);
		posn[2] = clamp32(posn[2] + v.z);
		p.qw = 32'(orient[0]);
		p.qx = 32'(orient[1]);
		p.qy = 32'(orient[2]);
		p.qz = 32'(orient[3]);
		p.px = 32'(posn[0]);
		p.py = 32'(posn[1]);
		p.pz = 32'(posn[2]);
		poses_expected.push_back(p);
	endtask

	function automatic tick_t mk_tick(int r, int h, int a, int s, int u, int f, bit d);
		tick_t t;
		t.roll = 16'(r);
		t.heading = 16'(h);
		t.attitude = 16'(a);
		t.side = 24'(s);
		t.up = 24'(u);
		t.fwd = 24'(f);
		t.drain = d;
		return t;
	endfunction

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 1024)) - 512);
			2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($signed($urandom_range(0, 16384)) - 8192);
		endcase
	endfunction

	function automatic logic [23:0] rand_move();
		case ($urandom_range(0, 2))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 131072)) - 65536);
			default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
		endcase
	endfunction

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		logic hold;
		tick_t t;
		hold = in_valid && !in_fire;
		if (arst_n && !hold) begin
			if (in_gap > 0) begin
				in_gap--;
			end else if (ticks_pending.size() > 0 &&
					!(ticks_pending[0].drain && poses_expected.size() > 0)) begin
				t = ticks_pending.pop_front();
				roll_deg <= t.roll;
				heading_deg <= t.heading;
				attitude_deg <= t.attitude;
				move_side <= t.side;
				move_up <= t.up;
				move_fwd <= t.fwd;
				hold = 1;
				send_count++;
				// stretches with no idling every so often
				in_gap = ((send_count / 100) % 3 == 1) ? 0 : $urandom_range(0, 18);
			end
		end
		in_valid <= hold;
		if (out_fire) begin
			recv_count++;
			out_stall = ((recv_count / 100) % 3 == 2) ? 0 : $urandom_range(0, 18);
		end
		if (out_stall > 0) begin
			out_stall--;
			out_ready <= 0;
		end else begin
			out_ready <= arst_n;
		end
	end

	// monitor: sample on the rising edge
	always @(posedge clk) begin
		pose_t e;
		in_fire <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (in_valid && in_ready)
			predict_pose('{roll_deg, heading_deg, attitude_deg, move_side, move_up, move_fwd, 0});
		if (out_valid && out_ready) begin
			if (poses_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: q %h %h %h %h p %h %h %h",
						quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z);
			end else begin
				e = poses_expected.pop_front();
				if ({quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z} !==
						{e.qw, e.qx, e.qy, e.qz, e.px, e.py, e.pz}) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("word mismatch: exp q %h %h %h %h p %h %h %h",
							e.qw, e.qx, e.qy, e.qz, e.px, e.py, e.pz);
						$display("               got q %h %h %h %h p %h %h %h",
							quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z);
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (idle_cycles >= 60000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		orient = '{64'h40000000, 0, 0, 0};
		posn = '{0, 0, 0};
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		{roll_deg, heading_deg, attitude_deg} = '0;
		{move_side, move_up, move_fwd} = '0;

		// directed: zero tick, angle and move extremes, right angles
		ticks_pending.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
		ticks_pending.push_back(mk_tick(32767, 0, 0, 0, 0, 0, 0));
		ticks_pending.push_back(mk_tick(-32768, 0, 0, 0, 0, 0, 0));
		ticks_pending.push_back(mk_tick(0, 32767, 0, 0, 0, 0, 0));
		ticks_pending.push_back(mk_tick(0, -32768, 0, 0, 0, 0, 0));
		ticks_pending.push_back(mk_tick(0, 0, 32767, 0, 0, 0, 0));
		ticks_pending.push_back(mk_tick(0, 0, -32768, 0, 0, 0, 0));
		ticks_pending.push_back(mk_tick(1, -1, 1, 1, -1, 1, 0));
		ticks_pending.push_back(mk_tick(23040, 0, 0, 8388607, 0, 0, 0));
		ticks_pending.push_back(mk_tick(0, 23040, 0, 0, 8388607, 0, 1));
		ticks_pending.push_back(mk_tick(0, 0, 23040, 0, 0, 8388607, 0));
		ticks_pending.push_back(mk_tick(0, 0, 0, -8388608, -8388608, -8388608, 0));
		ticks_pending.push_back(mk_tick(32767, 32767, 32767, 8388607, 8388607, 8388607, 0));
		ticks_pending.push_back(mk_tick(-32768, -32768, -32768, -8388608, -8388608,
			-8388608, 0));
		ticks_pending.push_back(mk_tick(-23040, 11520, -5760, 65536, -65536, 32768, 0));
		ticks_pending.push_back(mk_tick(256, 512, -768, 0, 0, 0, 1));
		// random ticks
		for (int i = 0; i < 500; i++)
			ticks_pending.push_back(mk_tick(rand_angle(), rand_angle(), rand_angle(),
				rand_move(), rand_move(), rand_move(), i == 250));
		// fixed attitude, full-size moves one way: position is driven toward its limits
		for (int i = 0; i < 300; i++)
			ticks_pending.push_back(mk_tick(0, 0, 0, -8388608, 8388607, -8388608, i == 0));
		// then the other way, back toward the opposite limits
		for (int i = 0; i < 600; i++)
			ticks_pending.push_back(mk_tick(0, 0, 0, 8388607, -8388608, 8388607, 0));
		for (int i = 0; i < 300; i++)
			ticks_pending.push_back(mk_tick(rand_angle(), rand_angle(), rand_angle(),
				rand_move(), rand_move(), rand_move(), 0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		while (ticks_pending.size() > 0)
			@(posedge clk);
		@(posedge clk);
		while (in_valid || poses_expected.size() > 0)
			@(posedge clk);
		repeat (4000) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

FILE: filelist.f
src/qpi_pkg.sv
src/qpi_rf.sv
src/qpi_mul.sv
src/qpi_divsqrt.sv
src/qpi_cordic.sv
src/quaternion_pose_integrator.sv
tb/quaternion_pose_integrator_test.sv
